FILE: rtl/tli_pkg.sv
package tli_pkg;

  localparam int KeyW   = 24;
  localparam int ValW   = 26;
  localparam int SlotW  = 4;
  localparam int CountW = 5;
  localparam int ProdW  = KeyW + ValW;
  localparam int StepW  = $clog2(ValW);
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  localparam logic [CountW-1:0] CountReset = 5'd14;
  localparam logic [CountW-1:0] CountMin   = 5'd2;

  // Register index as seen in paddr above the byte offset.
  localparam logic [AddrW-3:0] RegEntryCount = 1'b0;

  typedef enum logic [0:0] {
    ModeLoad  = 1'b0,
    ModeQuery = 1'b1
  } tli_mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StFin,
    StDone
  } tli_state_e;

  typedef struct packed {
    tli_mode_e         mode;
    logic [SlotW-1:0]  slot;
    logic [KeyW-1:0]   entry_key;
    logic [ValW-1:0]   entry_value;
    logic [KeyW-1:0]   query_altitude;
  } tli_in_t;

  typedef struct packed {
    logic [ValW-1:0] mach_speed;
    logic            out_of_range;
  } tli_out_t;

  // Query packet that walks the row of cells.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] alt;
    logic            match;
    logic            clamp;
    logic            brk;
    logic [ValW-1:0] rval;
    logic [KeyW-1:0] prev_key;
    logic [ValW-1:0] prev_val;
    logic [KeyW-1:0] x0;
    logic [ValW-1:0] y0;
    logic [KeyW-1:0] x1;
    logic [ValW-1:0] y1;
  } tli_pkt_t;

  typedef struct packed {
    logic used;
    logic first;
    logic last;
    logic we;
  } tli_cell_ctrl_t;

  typedef struct packed {
    logic            direct;
    logic            flag;
    logic [ValW-1:0] rval;
    logic [KeyW-1:0] alt;
    logic [KeyW-1:0] x0;
    logic [ValW-1:0] y0;
    logic [KeyW-1:0] x1;
    logic [ValW-1:0] y1;
  } tli_job_t;

  typedef struct packed {
    logic idle;
    logic done;
  } tli_stat_t;

endpackage

FILE: rtl/tli_cell.sv
module tli_cell import tli_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tli_cell_ctrl_t       ctrl_i,
  input  logic [KeyW-1:0]      key_i,
  input  logic [ValW-1:0]      value_i,
  input  tli_pkt_t             pkt_i,
  output tli_pkt_t             pkt_o
);

  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic            valid_q;
  tli_pkt_t        pkt_d;
  tli_pkt_t        pkt_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      key_q <= key_i;
      val_q <= value_i;
    end
  end

  always_comb begin
    pkt_d          = pkt_i;
    pkt_d.prev_key = key_q;
    pkt_d.prev_val = val_q;
    if (ctrl_i.used) begin
      // An exact hit in a lower slot wins and overrides any earlier clamp.
      priority if (!pkt_i.match && (key_q == pkt_i.alt)) begin
        pkt_d.match = 1'b1;
        pkt_d.rval  = val_q;
      end else if (!pkt_i.match && !pkt_i.clamp && ctrl_i.first &&
                   (pkt_i.alt < key_q)) begin
        pkt_d.clamp = 1'b1;
        pkt_d.rval  = val_q;
      end else if (!pkt_i.match && !pkt_i.clamp && ctrl_i.last &&
                   (pkt_i.alt > key_q)) begin
        pkt_d.clamp = 1'b1;
        pkt_d.rval  = val_q;
      end
      // The first key above the query closes the bracket with its left neighbor.
      if (!pkt_i.brk && !ctrl_i.first && (key_q > pkt_i.alt)) begin
        pkt_d.brk = 1'b1;
        pkt_d.x0  = pkt_i.prev_key;
        pkt_d.y0  = pkt_i.prev_val;
        pkt_d.x1  = key_q;
        pkt_d.y1  = val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pkt_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
  end

  always_comb begin
    pkt_o       = pkt_q;
    pkt_o.valid = valid_q;
  end

endmodule

FILE: rtl/tli_interp.sv
module tli_interp import tli_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  tli_job_t  job_i,
  input  logic      res_ready_i,
  output tli_stat_t stat_o,
  output tli_out_t  res_o
);

  tli_state_e       state_q, state_d;
  logic             neg_q;
  logic [ValW-1:0]  diff_q;
  logic [KeyW-1:0]  off_q;
  logic [KeyW-1:0]  span_q;
  logic [ValW-1:0]  y0_q;
  logic [ProdW-1:0] prod;
  logic [KeyW-1:0]  rem_q;
  logic [ValW-1:0]  dvd_q;
  logic [StepW-1:0] cnt_q;
  logic [KeyW:0]    trial;
  tli_out_t         res_q;

  assign prod  = ProdW'(diff_q) * ProdW'(off_q);
  assign trial = {rem_q, dvd_q[ValW-1]} - {1'b0, span_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = job_i.direct ? StDone : StMul;
        end
      end
      StMul: state_d = StDiv;
      StDiv: begin
        if (cnt_q == StepW'(ValW - 1)) begin
          state_d = StFin;
        end
      end
      StFin: state_d = StDone;
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    stat_o.idle = (state_q == StIdle);
    stat_o.done = (state_q == StDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        res_q.mach_speed   <= job_i.rval;
        res_q.out_of_range <= job_i.flag;
        neg_q  <= (job_i.y1 < job_i.y0);
        diff_q <= (job_i.y1 < job_i.y0) ? (job_i.y0 - job_i.y1) : (job_i.y1 - job_i.y0);
        off_q  <= job_i.alt - job_i.x0;
        span_q <= job_i.x1 - job_i.x0;
        y0_q   <= job_i.y0;
      end
      StMul: begin
        // The quotient is below the value difference, so the top bits start below span.
        rem_q <= prod[ProdW-1:ValW];
        dvd_q <= prod[ValW-1:0];
        cnt_q <= '0;
      end
      StDiv: begin
        if (!trial[KeyW]) begin
          rem_q <= trial[KeyW-1:0];
          dvd_q <= {dvd_q[ValW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[KeyW-2:0], dvd_q[ValW-1]};
          dvd_q <= {dvd_q[ValW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + StepW'(1);
      end
      StFin: begin
        res_q.mach_speed   <= neg_q ? (y0_q - dvd_q) : (y0_q + dvd_q);
        res_q.out_of_range <= 1'b0;
      end
      StDone: begin
        res_q <= res_q;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

FILE: rtl/table_linear_interpolator_top.sv
// Load beats are written into the table at acceptance and give no result, one per cycle
// while no query is in flight. A query beat walks one cell per cycle through ENTRIES
// cells, then takes a multiply step and a restoring divide; its result beat becomes valid
// in the output register, and from then on the next beat can be accepted too.
// Exact hits and clamped queries skip the multiply and the divide.
// Reset clears control state and sets entry_count to 14; the table is undefined until loaded.
module table_linear_interpolator_top import tli_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tli_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tli_out_t         out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int CntW = ($clog2(ENTRIES + 1) > CountW) ? $clog2(ENTRIES + 1) : CountW;

  logic [CountW-1:0] entry_count_q;
  logic [CntW-1:0]   count_ext;
  logic [CntW-1:0]   used_n;
  logic              busy_q;
  logic              in_acc;
  logic              load_acc;
  logic              query_acc;
  logic              out_valid_q;
  tli_out_t          out_q;
  tli_pkt_t          pkt [ENTRIES+1];
  logic [ENTRIES-1:0] pkt_valid;
  tli_job_t          job;
  tli_stat_t         stat;
  tli_out_t          res;
  logic              res_ready;
  logic              reg_sel;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[AddrW-1:2] == RegEntryCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= CountReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      entry_count_q <= pwdata[CountW-1:0];
    end
  end

  assign prdata = reg_sel ? DataW'(entry_count_q) : '0;

  always_comb begin
    count_ext = CntW'(entry_count_q);
    priority if (count_ext < CntW'(CountMin)) begin
      used_n = CntW'(CountMin);
    end else if (count_ext > CntW'(ENTRIES)) begin
      used_n = CntW'(ENTRIES);
    end else begin
      used_n = count_ext;
    end
  end

  // Input side.
  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && (in_data_i.mode == ModeLoad);
  assign query_acc  = in_acc && (in_data_i.mode == ModeQuery);

  always_comb begin
    pkt[0]       = '0;
    pkt[0].valid = query_acc;
    pkt[0].alt   = in_data_i.query_altitude;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tli_cell_ctrl_t ctrl;

    always_comb begin
      ctrl.used  = (CntW'(i) < used_n);
      ctrl.first = (i == 0);
      ctrl.last  = (CntW'(i) == (used_n - CntW'(1)));
      ctrl.we    = load_acc && (CntW'(in_data_i.slot) == CntW'(i));
    end

    tli_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .key_i   (in_data_i.entry_key),
      .value_i (in_data_i.entry_value),
      .pkt_i   (pkt[i]),
      .pkt_o   (pkt[i+1])
    );

    assign pkt_valid[i] = pkt[i+1].valid;
  end

  // The packet leaving the last cell selects hit, clamp or interpolation.
  always_comb begin
    job.direct = pkt[ENTRIES].match || pkt[ENTRIES].clamp;
    job.flag   = !pkt[ENTRIES].match && pkt[ENTRIES].clamp;
    job.rval   = pkt[ENTRIES].rval;
    job.alt    = pkt[ENTRIES].alt;
    job.x0     = pkt[ENTRIES].x0;
    job.y0     = pkt[ENTRIES].y0;
    job.x1     = pkt[ENTRIES].x1;
    job.y1     = pkt[ENTRIES].y1;
  end

  assign res_ready = !out_valid_q || out_ready_i;

  tli_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (pkt[ENTRIES].valid),
    .job_i       (job),
    .res_ready_i (res_ready),
    .stat_o      (stat),
    .res_o       (res)
  );

  // Output register; the next query may start while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (query_acc) begin
        busy_q <= 1'b1;
      end else if (stat.done && res_ready) begin
        busy_q <= 1'b0;
      end
      if (stat.done && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_query_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pkt_valid))
    else $error("more than one query packet in the cell row");

  a_exit_finds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt[ENTRIES].valid |-> stat.idle)
    else $error("query left the cell row while the interpolator was busy");

  a_work_means_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!stat.idle || (pkt_valid != '0)) |-> busy_q)
    else $error("query in flight while the input side reports free");

endmodule
